// ===== hw/rtl/rc4_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 stream cipher core.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KEY_W  = 64;
    localparam int unsigned KIDX_W = 4;

    typedef logic [BYTE_W-1:0] byte_t;

    // Sequencer states: key schedule (fill, keyed swaps) and byte generation
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RD,
        ST_KS_J,
        ST_KS_WN,
        ST_KS_WJ,
        ST_RD_I,
        ST_RD_J,
        ST_WR_I,
        ST_WR_J,
        ST_OUT
    } rc4_state_t;

    // Permutation memory request, one write and one read port per cycle
    typedef struct packed {
        logic  we;
        byte_t waddr;
        byte_t wdata;
        byte_t raddr;
    } rc4_mem_req_t;

    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

endpackage : rc4_pkg
`default_nettype wire

// ===== hw/rtl/rc4_sbox.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_sbox
// 256 x 8 permutation memory, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rc4_sbox
    import rc4_pkg::*;
(
    input  wire logic         clk,
    input  wire rc4_mem_req_t req,
    output byte_t             rdata
);

    byte_t mem [256];
    byte_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read-before-write on a same-address collision
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule : rc4_sbox
`default_nettype wire

// ===== hw/rtl/rc4_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for key schedule and keystream generation around one shared
// 8-bit three-input adder and the permutation memory port.
// ----------------------------------------------------------------------------
module rc4_ctrl
    import rc4_pkg::*;
#(
    parameter int unsigned KEY_BYTES = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 restart,
    input  wire byte_t                data_in,
    input  wire logic [2*KEY_W-1:0]   key,
    input  wire logic                 res_free,
    input  wire byte_t                rdata,
    output rc4_mem_req_t              req,
    output logic                      idle,
    output logic                      res_valid,
    output byte_t                     res_byte
);

    rc4_state_t state_reg, state_next;

    byte_t              cnt_reg;
    logic [KIDX_W-1:0]  kidx_reg;
    byte_t              i_reg;
    byte_t              j_reg;
    byte_t              si_reg;
    byte_t              sj_reg;
    byte_t              t_reg;
    byte_t              data_reg;

    byte_t add_a, add_b, add_c, sum;
    byte_t key_byte;
    logic  last_n;

    assign key_byte = key[{kidx_reg, 3'b000} +: BYTE_W];
    assign last_n   = (cnt_reg == 8'hFF);

    // shared adder
    always_comb
    begin
        add_a = j_reg;
        add_b = rdata;
        add_c = '0;
        case (state_reg)
            ST_KS_J: add_c = key_byte;
            ST_WR_J:
            begin
                add_a = si_reg;
                add_b = sj_reg;
            end
            default: add_c = '0;
        endcase
    end

    assign sum = add_a + add_b + add_c;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = restart ? ST_FILL : ST_RD_I;
            ST_FILL:  if (last_n) state_next = ST_KS_RD;
            ST_KS_RD: state_next = ST_KS_J;
            ST_KS_J:  state_next = ST_KS_WN;
            ST_KS_WN: state_next = ST_KS_WJ;
            ST_KS_WJ: state_next = last_n ? ST_RD_I : ST_KS_RD;
            ST_RD_I:  state_next = ST_RD_J;
            ST_RD_J:  state_next = ST_WR_I;
            ST_WR_I:  state_next = ST_WR_J;
            ST_WR_J:  state_next = ST_OUT;
            ST_OUT:   if (res_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req.we    = 1'b0;
        req.waddr = cnt_reg;
        req.wdata = cnt_reg;
        req.raddr = t_reg;
        idle      = 1'b0;
        res_valid = 1'b0;
        // S[t] forwards si when the read raced the S[j] write
        res_byte  = data_reg ^ ((t_reg == j_reg) ? si_reg : rdata);
        unique case (state_reg)
            ST_IDLE:  idle = 1'b1;
            ST_FILL:  req.we = 1'b1;
            ST_KS_RD: req.raddr = cnt_reg;
            ST_KS_J:  req.raddr = sum;
            ST_KS_WN:
            begin
                req.we    = 1'b1;
                req.wdata = rdata;
            end
            ST_KS_WJ:
            begin
                req.we    = 1'b1;
                req.waddr = j_reg;
                req.wdata = si_reg;
            end
            ST_RD_I:  req.raddr = i_reg;
            ST_RD_J:  req.raddr = sum;
            ST_WR_I:
            begin
                req.we    = 1'b1;
                req.waddr = i_reg;
                req.wdata = rdata;
            end
            ST_WR_J:
            begin
                req.we    = 1'b1;
                req.waddr = j_reg;
                req.wdata = si_reg;
                req.raddr = sum;
            end
            ST_OUT:   res_valid = 1'b1;
            default:  idle = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            kidx_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        i_reg   <= i_reg + 8'd1;
                        cnt_reg <= '0;
                    end
                end
                ST_FILL:
                begin
                    cnt_reg <= cnt_reg + 8'd1;
                    if (last_n)
                    begin
                        j_reg    <= '0;
                        kidx_reg <= '0;
                    end
                end
                ST_KS_J:  j_reg <= sum;
                ST_KS_WJ:
                begin
                    cnt_reg <= cnt_reg + 8'd1;
                    if (kidx_reg == KIDX_W'(KEY_BYTES - 1))
                    begin
                        kidx_reg <= '0;
                    end
                    else
                    begin
                        kidx_reg <= kidx_reg + 1'b1;
                    end
                    if (last_n)
                    begin
                        i_reg <= 8'd1;
                        j_reg <= '0;
                    end
                end
                ST_RD_J:  j_reg <= sum;
                default:  cnt_reg <= cnt_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            data_reg <= data_in;
        end
        if (state_reg == ST_KS_J || state_reg == ST_RD_J)
        begin
            si_reg <= rdata;
        end
        if (state_reg == ST_WR_I)
        begin
            sj_reg <= rdata;
        end
        if (state_reg == ST_WR_J)
        begin
            t_reg <= sum;
        end
    end

endmodule : rc4_ctrl
`default_nettype wire

// ===== hw/rtl/rc4_stream_cipher_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// RC4 stream cipher: key registers, sequencer, permutation memory and an
// output register.
// ----------------------------------------------------------------------------
//  Channel  | Signals                         | Contents
//  ---------+---------------------------------+-------------------------------
//  s_axis   | s_tvalid s_tready s_tdata s_tuser | data_byte, restart flag
//  m_axis   | m_tvalid m_tready m_tdata       | out_byte
//  config   | cfg_we cfg_index cfg_wdata      | 0: key_low, 1: key_high
//
// A byte runs through the serial read / swap / keystream-read steps on the
// single memory port; ready stays low until they are through, and ready and
// the output come back in the same cycle.
// A restart byte first adds 256 fill writes, then 256 keyed swaps.
// Reset clears the sequencer, the indices and the keys; the permutation is
// undefined until the first restart. A stalled output holds the sequencer
// in its final step; the output register frees the input side otherwise.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core
    import rc4_pkg::*;
#(
    parameter int unsigned KEY_BYTES = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,    // [7:0] data_byte
    input  wire logic             s_tuser,    // [0] restart
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,    // [7:0] out_byte
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [KEY_W-1:0] cfg_wdata
);

    logic [KEY_W-1:0] key_low_reg;
    logic [KEY_W-1:0] key_high_reg;
    logic             m_tvalid_reg;
    byte_t            m_tdata_reg;

    rc4_mem_req_t req;
    byte_t        rdata;
    logic         idle;
    logic         res_valid;
    byte_t        res_byte;
    logic         res_free;
    logic         start;

    assign s_tready = idle;
    assign start    = s_tvalid & idle;
    assign res_free = ~m_tvalid_reg | m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                CFG_KEY_HIGH: key_high_reg <= cfg_wdata;
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    rc4_ctrl #(
        .KEY_BYTES (KEY_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .restart   (s_tuser),
        .data_in   (s_tdata),
        .key       ({key_high_reg, key_low_reg}),
        .res_free  (res_free),
        .rdata     (rdata),
        .req       (req),
        .idle      (idle),
        .res_valid (res_valid),
        .res_byte  (res_byte)
    );

    rc4_sbox u_sbox (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_free && res_valid)
        begin
            m_tdata_reg <= res_byte;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule : rc4_stream_cipher_core
`default_nettype wire

// ===== tb/rc4_stream_cipher_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core_tb
// Self-checking bench for the RC4 stream cipher core. A queue-fed driver pushes
// bytes (restart-flagged message starts, continuation bytes, stray restarts)
// into the input stream with random gaps. The output side is back-pressured at
// random. A byte-level RC4 predictor, updated at each accepted input and key
// write, supplies the expected output byte for every input transaction.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core_tb;
    import rc4_pkg::*;

    localparam int unsigned KEY_BYTES = 16;

    typedef struct packed {
        byte_t data;
        logic  restart;
    } cipher_item_t;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;
    logic             s_tuser   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [7:0]       m_tdata;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = CFG_KEY_LOW;
    logic [KEY_W-1:0] cfg_wdata = '0;

    // stimulus and scoreboard
    cipher_item_t     pending_bytes[$];
    byte_t            expected_cipher[$];
    int               mismatch_count = 0;
    int               src_idle_pct   = 23;
    int               snk_idle_pct   = 23;
    logic             in_fire        = 1'b0;

    // predictor state
    byte_t            perm [256];
    byte_t            gen_i    = '0;
    byte_t            gen_j    = '0;
    logic [KEY_W-1:0] key_lo_m = '0;
    logic [KEY_W-1:0] key_hi_m = '0;

    rc4_stream_cipher_core #(
        .KEY_BYTES (KEY_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic byte_t key_at(int unsigned n);
        int unsigned      b;
        logic [KEY_W-1:0] word;
        b    = n & 15;
        word = (b < 8) ? key_lo_m : key_hi_m;
        return word[(b % 8) * 8 +: 8];
    endfunction

    function automatic void run_key_schedule();
        byte_t j;
        byte_t t;
        j = '0;
        for (int n = 0; n < 256; n++)
            perm[n] = byte_t'(n);
        for (int n = 0; n < 256; n++)
        begin
            j       = j + perm[n] + key_at(n % KEY_BYTES);
            t       = perm[n];
            perm[n] = perm[j];
            perm[j] = t;
        end
        gen_i = '0;
        gen_j = '0;
    endfunction

    function automatic byte_t rc4_transform(byte_t data, logic restart);
        byte_t t;
        byte_t sel;
        if (restart)
            run_key_schedule();
        gen_i       = gen_i + 8'd1;
        gen_j       = gen_j + perm[gen_i];
        t           = perm[gen_i];
        perm[gen_i] = perm[gen_j];
        perm[gen_j] = t;
        sel         = perm[gen_i] + perm[gen_j];
        return data ^ perm[sel];
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // Driver: input stream and output back-pressure, updated on falling edges
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        cipher_item_t it;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || in_fire)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    it = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= it.data;
                    s_tuser  <= it.restart;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: key writes, input transactions and output checks on rising edges
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        byte_t exp_byte;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_KEY_LOW)
                    key_lo_m = cfg_wdata;
                else
                    key_hi_m = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                expected_cipher.push_back(rc4_transform(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
            begin
                if (expected_cipher.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected output byte %02h", m_tdata));
                end
                else
                begin
                    exp_byte = expected_cipher.pop_front();
                    if (m_tdata !== exp_byte)
                        report_mismatch($sformatf("out_byte got %02h want %02h",
                                                  m_tdata, exp_byte));
                end
            end
            in_fire <= s_tvalid && s_tready;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_key(logic idx, logic [KEY_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // waits until the core has consumed and answered everything queued;
    // checked on rising edges, where s_tvalid is settled
    task automatic wait_for_drain();
        while (!(pending_bytes.size() == 0 && !s_tvalid && expected_cipher.size() == 0))
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic push_byte(byte_t data, logic restart);
        cipher_item_t it;
        it.data    = data;
        it.restart = restart;
        pending_bytes.push_back(it);
    endtask

    // messages of random length; first one optionally continues the old stream
    task automatic queue_messages(int count, logic start_restart);
        int   left;
        int   len;
        logic first_flag;
        left       = count;
        first_flag = start_restart;
        while (left > 0)
        begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(200, 400);   // long message, cut to the count still left
            else
                len = $urandom_range(1, 60);
            if (len > left)
                len = left;
            for (int k = 0; k < len; k++)
                push_byte(byte_t'($urandom),
                          (k == 0 && first_flag) || ($urandom_range(99) < 2));
            left       -= len;
            first_flag  = 1'b1;
        end
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [KEY_W-1:0] lo_val;
        logic [KEY_W-1:0] hi_val;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: all-zero key, data extremes, back-to-back restarts
        write_key(CFG_KEY_LOW, '0);
        write_key(CFG_KEY_HIGH, '0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hFE, 1'b0);
        wait_for_drain();

        // all-ones key: no effect until the next restart
        write_key(CFG_KEY_LOW, '1);
        write_key(CFG_KEY_HIGH, '1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h3C, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hC3, 1'b0);
        wait_for_drain();

        // distinct key bytes, to catch byte ordering errors
        write_key(CFG_KEY_LOW, 64'h0706050403020100);
        write_key(CFG_KEY_HIGH, 64'h0F0E0D0C0B0A0908);
        push_byte(8'h12, 1'b1);
        push_byte(8'h34, 1'b0);
        push_byte(8'h56, 1'b0);
        push_byte(8'h78, 1'b0);
        wait_for_drain();

        // random phases, with a key setting change between phases
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       begin lo_val = '1;                 hi_val = '0;                 end
                4:       begin lo_val = '0;                 hi_val = '1;                 end
                6:       begin lo_val = 64'h5555AAAA5555AAAA; hi_val = 64'hAAAA5555AAAA5555; end
                default: begin lo_val = random_key();       hi_val = random_key();       end
            endcase
            if (p != 2)
                write_key(CFG_KEY_LOW, lo_val);
            if (p != 5)
                write_key(CFG_KEY_HIGH, hi_val);
            src_idle_pct = (p == 3) ? 0 : 23;
            snk_idle_pct = (p == 3) ? 0 : 23;
            queue_messages(200, $urandom_range(1));
            wait_for_drain();
        end

        src_idle_pct = 23;
        repeat (50) @(negedge clk);
        while (expected_cipher.size() > 0)
        begin
            report_mismatch($sformatf("missing output, want %02h", expected_cipher[0]));
            void'(expected_cipher.pop_front());
        end
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
